/* sv/fvm_pkg.sv */
`timescale 1ns / 1ps
// fvm_pkg: shared types and constants for the FAT volume mount and cluster map.
// No dependencies.
package fvm_pkg;

  localparam int BOOT_SECTOR_BYTES = 512;
  localparam int MAX_SECTOR_BYTES  = 4096;
  localparam int POS_W             = $clog2(MAX_SECTOR_BYTES + 1);

  localparam logic [1:0] OPC_BYTE   = 2'd0;
  localparam logic [1:0] OPC_FIRST  = 2'd1;
  localparam logic [1:0] OPC_LOOKUP = 2'd2;

  localparam logic [7:0]  JMP_SHORT          = 8'hEB;
  localparam logic [7:0]  JMP_NEAR           = 8'hE9;
  localparam logic [31:0] FAT32_MIN_CLUSTERS = 32'd65525;
  localparam logic [31:0] FAT32_ENTRY_MASK   = 32'h0FFF_FFFF;

  // boot sector field offsets
  localparam logic [POS_W-1:0] OFS_BPS      = POS_W'(12'h00B);
  localparam logic [POS_W-1:0] OFS_SPC      = POS_W'(12'h00D);
  localparam logic [POS_W-1:0] OFS_RSVD     = POS_W'(12'h00E);
  localparam logic [POS_W-1:0] OFS_NFATS    = POS_W'(12'h010);
  localparam logic [POS_W-1:0] OFS_ROOTENT  = POS_W'(12'h011);
  localparam logic [POS_W-1:0] OFS_TOT16    = POS_W'(12'h013);
  localparam logic [POS_W-1:0] OFS_FAT16    = POS_W'(12'h016);
  localparam logic [POS_W-1:0] OFS_TOT32    = POS_W'(12'h020);
  localparam logic [POS_W-1:0] OFS_FAT32    = POS_W'(12'h024);
  localparam logic [POS_W-1:0] OFS_ROOTCLUS = POS_W'(12'h02C);
  localparam logic [POS_W-1:0] OFS_PSTART   = POS_W'(12'h1C6);

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_FIRST,
    OP_LOOKUP,
    OP_NONE
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  data;
    logic        last;
    logic [27:0] cluster;
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_MOUNTED = 3'd1,
    KIND_ERROR   = 3'd2,
    KIND_FIRST   = 3'd3,
    KIND_NEXT    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_BOOT0,
    PH_BOOT1,
    PH_READY,
    PH_FAT,
    PH_FAIL
  } phase_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SPAN,
    SEQ_CC_START,
    SEQ_CC_WAIT,
    SEQ_BASES,
    SEQ_ROOT,
    SEQ_LOOKUP
  } seq_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

/* sv/fvm_front.sv */
`timescale 1ns / 1ps
// fvm_front: accepts input transactions, decodes the operation and queues commands.
// Depends on fvm_pkg.
module fvm_front import fvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [27:0] cluster_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  // classify the operation
  always_comb begin
    cmd_in.data    = data_byte_i;
    cmd_in.last    = last_byte_i;
    cmd_in.cluster = cluster_i;
    case (operation_i)
      OPC_BYTE:   cmd_in.op = OP_BYTE;
      OPC_FIRST:  cmd_in.op = OP_FIRST;
      OPC_LOOKUP: cmd_in.op = OP_LOOKUP;
      default:    cmd_in.op = OP_NONE;
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  // two-entry command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_q[wr_ptr_q] <= cmd_in;
  end

endmodule

/* sv/fvm_div.sv */
`timescale 1ns / 1ps
// fvm_div: iterative restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on fvm_pkg.
module fvm_div import fvm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [15:0] rem_q, den_q;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_q, quo_q[31]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        den_q  <= req_i.divisor;
      end else if (busy_q) begin
        // shift in one dividend bit, subtract when it fits
        rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        quo_q <= {quo_q[30:0], fits};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* sv/fvm_back.sv */
`timescale 1ns / 1ps
// fvm_back: executes queued commands: boot sector capture, mount arithmetic, queries.
// Depends on fvm_pkg and fvm_div.
module fvm_back import fvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] sector_o,
  output logic [27:0] next_cluster_o,
  output logic        is_fat32_o,
  output logic [15:0] bytes_per_sector_o,
  output logic [7:0]  sectors_per_cluster_o,
  output logic [31:0] fat_start_sector_o,
  output logic [31:0] first_data_sector_o,
  output logic [31:0] root_dir_sector_o,
  output logic [15:0] root_dir_sectors_o,
  output logic [31:0] data_clusters_o
);

  phase_e phase_q, phase_d;
  seq_e   seq_q, seq_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0] pstart_q, pstart_d;
  logic        hdr_q, hdr_d;
  logic [15:0] bps_q, bps_d, rsvd_q, rsvd_d, rootent_q, rootent_d;
  logic [15:0] tot16_q, tot16_d, fat16_q, fat16_d;
  logic [7:0]  spc_q, spc_d, nfats_q, nfats_d;
  logic [31:0] tot32_q, tot32_d, fat32_q, fat32_d, rclus_q, rclus_d;
  logic [31:0] rc_q, rc_d, fatspan_q, fatspan_d, rootmul_q, rootmul_d;
  // volume values
  logic        wide_q, wide_d;
  logic [15:0] vbps_q, vbps_d, span_q, span_d;
  logic [7:0]  vspc_q, vspc_d;
  logic [31:0] fbase_q, fbase_d, dbase_q, dbase_d, rbase_q, rbase_d, ccnt_q, ccnt_d;
  // lookup
  logic [15:0] eoff_q, eoff_d;
  logic [31:0] eval_q, eval_d;
  // result register
  logic        ovld_q, ovld_d;
  kind_e       okind_q, okind_d;
  logic [31:0] osec_q, osec_d;
  logic [27:0] onext_q, onext_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        may_emit;
  logic [15:0] ediff;
  logic [31:0] fo, fsz, dsecs;

  fvm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // command execution and mount sequencer
  always_comb begin
    phase_d = phase_q;  seq_d = seq_q;  pos_d = pos_q;  pstart_d = pstart_q;
    hdr_d = hdr_q;  bps_d = bps_q;  rsvd_d = rsvd_q;  rootent_d = rootent_q;
    tot16_d = tot16_q;  fat16_d = fat16_q;  spc_d = spc_q;  nfats_d = nfats_q;
    tot32_d = tot32_q;  fat32_d = fat32_q;  rclus_d = rclus_q;  rc_d = rc_q;
    fatspan_d = fatspan_q;  rootmul_d = rootmul_q;
    wide_d = wide_q;  vbps_d = vbps_q;  span_d = span_q;  vspc_d = vspc_q;
    fbase_d = fbase_q;  dbase_d = dbase_q;  rbase_d = rbase_q;  ccnt_d = ccnt_q;
    eoff_d = eoff_q;  eval_d = eval_q;
    ovld_d = ovld_q && !pop;  okind_d = okind_q;  osec_d = osec_q;  onext_d = onext_q;
    cmd_pop_o = 1'b0;
    div_req = '0;
    may_emit = !(cmd_i.op == OP_BYTE && !cmd_i.last);
    ediff = {{(16-POS_W){1'b0}}, pos_q} - eoff_q;
    fo = wide_q ? {2'b00, cmd_i.cluster, 2'b00} : {3'b000, cmd_i.cluster, 1'b0};
    fsz = (fat16_q != 16'd0) ? {16'd0, fat16_q} : fat32_q;
    dsecs = tot16_q != 16'd0 ? {16'd0, tot16_q} : tot32_q;
    dsecs = dsecs - ({16'd0, rsvd_q} + fatspan_q + {16'd0, span_q});

    case (seq_q)
      SEQ_IDLE: begin
        if (cmd_valid_i && (!may_emit || !ovld_q)) begin
          cmd_pop_o = 1'b1;
          case (phase_q)
            PH_FAIL: begin
              if (cmd_i.op == OP_FIRST || cmd_i.op == OP_LOOKUP) begin
                ovld_d = 1'b1;  okind_d = KIND_ERROR;  osec_d = '0;  onext_d = '0;
              end
            end
            PH_BOOT0, PH_BOOT1: begin
              if (cmd_i.op == OP_BYTE) begin
                if (pos_q == '0) begin
                  bps_d = '0;  spc_d = '0;  rsvd_d = '0;  nfats_d = '0;  rootent_d = '0;
                  tot16_d = '0;  fat16_d = '0;  tot32_d = '0;  fat32_d = '0;  rclus_d = '0;
                  if (phase_q == PH_BOOT0) pstart_d = '0;
                  hdr_d = (cmd_i.data == JMP_SHORT) || (cmd_i.data == JMP_NEAR);
                end
                // little-endian field capture
                if (pos_q < POS_W'(BOOT_SECTOR_BYTES)) begin
                  case (pos_q)
                    OFS_BPS:                   bps_d[7:0]      = cmd_i.data;
                    POS_W'(OFS_BPS + 1):       bps_d[15:8]     = cmd_i.data;
                    OFS_SPC:                   spc_d           = cmd_i.data;
                    OFS_RSVD:                  rsvd_d[7:0]     = cmd_i.data;
                    POS_W'(OFS_RSVD + 1):      rsvd_d[15:8]    = cmd_i.data;
                    OFS_NFATS:                 nfats_d         = cmd_i.data;
                    OFS_ROOTENT:               rootent_d[7:0]  = cmd_i.data;
                    POS_W'(OFS_ROOTENT + 1):   rootent_d[15:8] = cmd_i.data;
                    OFS_TOT16:                 tot16_d[7:0]    = cmd_i.data;
                    POS_W'(OFS_TOT16 + 1):     tot16_d[15:8]   = cmd_i.data;
                    OFS_FAT16:                 fat16_d[7:0]    = cmd_i.data;
                    POS_W'(OFS_FAT16 + 1):     fat16_d[15:8]   = cmd_i.data;
                    OFS_TOT32:                 tot32_d[7:0]    = cmd_i.data;
                    POS_W'(OFS_TOT32 + 1):     tot32_d[15:8]   = cmd_i.data;
                    POS_W'(OFS_TOT32 + 2):     tot32_d[23:16]  = cmd_i.data;
                    POS_W'(OFS_TOT32 + 3):     tot32_d[31:24]  = cmd_i.data;
                    OFS_FAT32:                 fat32_d[7:0]    = cmd_i.data;
                    POS_W'(OFS_FAT32 + 1):     fat32_d[15:8]   = cmd_i.data;
                    POS_W'(OFS_FAT32 + 2):     fat32_d[23:16]  = cmd_i.data;
                    POS_W'(OFS_FAT32 + 3):     fat32_d[31:24]  = cmd_i.data;
                    OFS_ROOTCLUS:              rclus_d[7:0]    = cmd_i.data;
                    POS_W'(OFS_ROOTCLUS + 1):  rclus_d[15:8]   = cmd_i.data;
                    POS_W'(OFS_ROOTCLUS + 2):  rclus_d[23:16]  = cmd_i.data;
                    POS_W'(OFS_ROOTCLUS + 3):  rclus_d[31:24]  = cmd_i.data;
                    OFS_PSTART:
                      if (phase_q == PH_BOOT0) pstart_d[7:0]   = cmd_i.data;
                    POS_W'(OFS_PSTART + 1):
                      if (phase_q == PH_BOOT0) pstart_d[15:8]  = cmd_i.data;
                    POS_W'(OFS_PSTART + 2):
                      if (phase_q == PH_BOOT0) pstart_d[23:16] = cmd_i.data;
                    POS_W'(OFS_PSTART + 3):
                      if (phase_q == PH_BOOT0) pstart_d[31:24] = cmd_i.data;
                    default: ;
                  endcase
                end
                if (pos_q < POS_W'(MAX_SECTOR_BYTES)) pos_d = pos_q + 1'b1;
                if (cmd_i.last) begin
                  pos_d = '0;
                  if (hdr_d) begin
                    if (phase_q == PH_BOOT0) pstart_d = '0;
                    if (bps_d == '0 || spc_d == '0) begin
                      phase_d = PH_FAIL;
                      ovld_d = 1'b1;  okind_d = KIND_ERROR;  osec_d = '0;  onext_d = '0;
                    end else begin
                      // root directory span: ceil(entries * 32 / bps)
                      div_req.start    = 1'b1;
                      div_req.dividend = {11'd0, rootent_d, 5'd0} + {16'd0, bps_d} - 32'd1;
                      div_req.divisor  = bps_d;
                      seq_d = SEQ_SPAN;
                    end
                  end else if (phase_q == PH_BOOT0) begin
                    phase_d = PH_BOOT1;
                    ovld_d = 1'b1;  okind_d = KIND_READ;  osec_d = pstart_d;  onext_d = '0;
                  end else begin
                    phase_d = PH_FAIL;
                    ovld_d = 1'b1;  okind_d = KIND_ERROR;  osec_d = '0;  onext_d = '0;
                  end
                end
              end
            end
            PH_FAT: begin
              if (cmd_i.op == OP_BYTE) begin
                if (pos_q == '0) eval_d = '0;
                if (pos_q < POS_W'(MAX_SECTOR_BYTES)) begin
                  if ({{(16-POS_W){1'b0}}, pos_q} >= eoff_q &&
                      ediff < (wide_q ? 16'd4 : 16'd2)) begin
                    case (ediff[1:0])
                      2'd0:    eval_d[7:0]   = cmd_i.data;
                      2'd1:    eval_d[15:8]  = cmd_i.data;
                      2'd2:    eval_d[23:16] = cmd_i.data;
                      default: eval_d[31:24] = cmd_i.data;
                    endcase
                  end
                  pos_d = pos_q + 1'b1;
                end
                if (cmd_i.last) begin
                  pos_d = '0;
                  phase_d = PH_READY;
                  ovld_d = 1'b1;  okind_d = KIND_NEXT;  osec_d = '0;
                  onext_d = wide_q ? eval_d[27:0] : {12'd0, eval_d[15:0]};
                end
              end
            end
            PH_READY: begin
              if (cmd_i.op == OP_FIRST) begin
                ovld_d = 1'b1;  okind_d = KIND_FIRST;  onext_d = '0;
                osec_d = (cmd_i.cluster == '0) ? rbase_q :
                         32'(({4'd0, cmd_i.cluster} - 32'd2) * vspc_q) + dbase_q;
              end else if (cmd_i.op == OP_LOOKUP) begin
                div_req.start    = 1'b1;
                div_req.dividend = fo;
                div_req.divisor  = (vbps_q != '0) ? vbps_q : 16'd1;
                eval_d = '0;
                pos_d = '0;
                phase_d = PH_FAT;
                seq_d = SEQ_LOOKUP;
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_SPAN: begin
        if (div_rsp.done) begin
          span_d = div_rsp.quot[15:0];
          fatspan_d = 32'(nfats_q * fsz);
          seq_d = SEQ_CC_START;
        end
      end
      SEQ_CC_START: begin
        // data clusters = data sectors / sectors per cluster
        div_req.start    = 1'b1;
        div_req.dividend = dsecs;
        div_req.divisor  = {8'd0, spc_q};
        seq_d = SEQ_CC_WAIT;
      end
      SEQ_CC_WAIT: begin
        if (div_rsp.done) begin
          ccnt_d = div_rsp.quot;
          wide_d = (div_rsp.quot >= FAT32_MIN_CLUSTERS);
          fbase_d = {16'd0, rsvd_q} + pstart_q;
          rc_d = (fat16_q != '0) ? 32'd0 : rclus_q;
          seq_d = SEQ_BASES;
        end
      end
      SEQ_BASES: begin
        dbase_d = fatspan_q + {16'd0, span_q} + fbase_q;
        rootmul_d = 32'((rc_q - 32'd2) * spc_q);
        seq_d = SEQ_ROOT;
      end
      SEQ_ROOT: begin
        rbase_d = wide_q ? rootmul_q + dbase_q : fbase_q + fatspan_q;
        vbps_d = bps_q;
        vspc_d = spc_q;
        phase_d = PH_READY;
        ovld_d = 1'b1;  okind_d = KIND_MOUNTED;  osec_d = '0;  onext_d = '0;
        seq_d = SEQ_IDLE;
      end
      SEQ_LOOKUP: begin
        if (div_rsp.done) begin
          eoff_d = div_rsp.rem;
          ovld_d = 1'b1;  okind_d = KIND_READ;  onext_d = '0;
          osec_d = div_rsp.quot + fbase_q;
          seq_d = SEQ_IDLE;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  // state and volume registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BOOT0;  seq_q <= SEQ_IDLE;  pos_q <= '0;  pstart_q <= '0;
      hdr_q <= 1'b0;  bps_q <= '0;  rsvd_q <= '0;  rootent_q <= '0;
      tot16_q <= '0;  fat16_q <= '0;  spc_q <= '0;  nfats_q <= '0;
      tot32_q <= '0;  fat32_q <= '0;  rclus_q <= '0;  rc_q <= '0;
      fatspan_q <= '0;  rootmul_q <= '0;
      wide_q <= 1'b0;  vbps_q <= '0;  span_q <= '0;  vspc_q <= '0;
      fbase_q <= '0;  dbase_q <= '0;  rbase_q <= '0;  ccnt_q <= '0;
      eoff_q <= '0;  eval_q <= '0;
      ovld_q <= 1'b0;  okind_q <= KIND_READ;  osec_q <= '0;  onext_q <= '0;
    end else begin
      phase_q <= phase_d;  seq_q <= seq_d;  pos_q <= pos_d;  pstart_q <= pstart_d;
      hdr_q <= hdr_d;  bps_q <= bps_d;  rsvd_q <= rsvd_d;  rootent_q <= rootent_d;
      tot16_q <= tot16_d;  fat16_q <= fat16_d;  spc_q <= spc_d;  nfats_q <= nfats_d;
      tot32_q <= tot32_d;  fat32_q <= fat32_d;  rclus_q <= rclus_d;  rc_q <= rc_d;
      fatspan_q <= fatspan_d;  rootmul_q <= rootmul_d;
      wide_q <= wide_d;  vbps_q <= vbps_d;  span_q <= span_d;  vspc_q <= vspc_d;
      fbase_q <= fbase_d;  dbase_q <= dbase_d;  rbase_q <= rbase_d;  ccnt_q <= ccnt_d;
      eoff_q <= eoff_d;  eval_q <= eval_d;
      ovld_q <= ovld_d;  okind_q <= okind_d;  osec_q <= osec_d;  onext_q <= onext_d;
    end
  end

  // volume values change only while no result waits
  assign empty                 = !ovld_q;
  assign kind_o                = okind_q;
  assign sector_o              = osec_q;
  assign next_cluster_o        = onext_q;
  assign is_fat32_o            = wide_q;
  assign bytes_per_sector_o    = vbps_q;
  assign sectors_per_cluster_o = vspc_q;
  assign fat_start_sector_o    = fbase_q;
  assign first_data_sector_o   = dbase_q;
  assign root_dir_sector_o     = rbase_q;
  assign root_dir_sectors_o    = span_q;
  assign data_clusters_o       = ccnt_q;

endmodule

/* sv/fat_volume_mount_and_cluster_map.sv */
`timescale 1ns / 1ps
// Result path, with the command queue empty: a result passes through the command queue
//   and then the result register; a mount result also waits for two 32-step divider
//   passes, and a next-cluster read request waits for one pass.
// Throughput: one sector byte per cycle; a result-causing transaction waits until the
//   previous result is popped, and the serial divider holds the queue while it runs.
// Asynchronous active-low reset; afterwards the block expects sector 0.
module fat_volume_mount_and_cluster_map import fvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [27:0] cluster_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [31:0] sector_o,
  output logic [27:0] next_cluster_o,
  output logic        is_fat32_o,
  output logic [15:0] bytes_per_sector_o,
  output logic [7:0]  sectors_per_cluster_o,
  output logic [31:0] fat_start_sector_o,
  output logic [31:0] first_data_sector_o,
  output logic [31:0] root_dir_sector_o,
  output logic [15:0] root_dir_sectors_o,
  output logic [31:0] data_clusters_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  fvm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cluster_i   (cluster_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  fvm_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_valid_i           (cmd_valid),
    .cmd_i                 (cmd),
    .cmd_pop_o             (cmd_pop),
    .empty                 (empty),
    .pop                   (pop),
    .kind_o                (kind_o),
    .sector_o              (sector_o),
    .next_cluster_o        (next_cluster_o),
    .is_fat32_o            (is_fat32_o),
    .bytes_per_sector_o    (bytes_per_sector_o),
    .sectors_per_cluster_o (sectors_per_cluster_o),
    .fat_start_sector_o    (fat_start_sector_o),
    .first_data_sector_o   (first_data_sector_o),
    .root_dir_sector_o     (root_dir_sector_o),
    .root_dir_sectors_o    (root_dir_sectors_o),
    .data_clusters_o       (data_clusters_o)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for fat_volume_mount_and_cluster_map.
// Depends on fvm_pkg and the block itself; a scoreboard class predicts each result.

import fvm_pkg::*;

typedef struct {
  kind_e       kind;
  logic [31:0] sector;
  logic [27:0] next_cl;
  logic        wide;
  logic [15:0] bps;
  logic [7:0]  spc;
  logic [31:0] fat_start;
  logic [31:0] data_start;
  logic [31:0] root_start;
  logic [15:0] root_secs;
  logic [31:0] clus_cnt;
} vol_result_t;

class fat_volume_scoreboard;

  vol_result_t expected_results[$];
  int unsigned errors;

  // mirrored block state
  phase_e      phase;
  logic [31:0] pos, part_start, hdr_ok;
  logic [31:0] f_bps, f_spc, f_rsvd, f_nfats, f_rootent, f_tot16, f_fat16;
  logic [31:0] f_tot32, f_fat32, f_rootclus;
  logic [31:0] fat_base, data_base, root_base, root_span, wide, clus_cnt;
  logic [31:0] vol_bps, vol_spc, entry_ofs, entry_val;

  function new();
    errors = 0;
    phase = PH_BOOT0;
    pos = 0; part_start = 0;
    clear_fields();
    fat_base = 0; data_base = 0; root_base = 0; root_span = 0;
    wide = 0; clus_cnt = 0; vol_bps = 0; vol_spc = 0;
    entry_ofs = 0; entry_val = 0;
  endfunction

  function void clear_fields();
    hdr_ok = 0; f_bps = 0; f_spc = 0; f_rsvd = 0; f_nfats = 0; f_rootent = 0;
    f_tot16 = 0; f_fat16 = 0; f_tot32 = 0; f_fat32 = 0; f_rootclus = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // little-endian field capture at byte position p
  function logic [31:0] take(logic [31:0] r, logic [31:0] p, logic [31:0] off,
                             logic [31:0] len, logic [7:0] b);
    if (p >= off && p - off < len) r = r | ({24'd0, b} << (8 * (p - off)));
    return r;
  endfunction

  function void add(kind_e k, logic [31:0] s, logic [31:0] nx);
    vol_result_t e;
    e.kind = k; e.sector = s; e.next_cl = nx[27:0];
    e.wide = wide[0]; e.bps = vol_bps[15:0]; e.spc = vol_spc[7:0];
    e.fat_start = fat_base; e.data_start = data_base; e.root_start = root_base;
    e.root_secs = root_span[15:0]; e.clus_cnt = clus_cnt;
    expected_results.push_back(e);
  endfunction

  // derive volume geometry; 0 on a zero divisor
  function bit mount();
    logic [31:0] span, tot, fsz, rc, fat_span, data_secs, cc;
    if (f_bps == 0 || f_spc == 0) return 0;
    span = ((f_rootent * 32 + f_bps - 1) / f_bps) & 32'hFFFF;
    tot = (f_tot16 != 0) ? f_tot16 : f_tot32;
    fsz = (f_fat16 != 0) ? f_fat16 : f_fat32;
    rc = (f_fat16 != 0) ? 32'd0 : f_rootclus;
    fat_span = f_nfats * fsz;
    data_secs = tot - (f_rsvd + fat_span + span);
    cc = data_secs / f_spc;
    wide = (cc >= FAT32_MIN_CLUSTERS) ? 32'd1 : 32'd0;
    root_span = span;
    clus_cnt = cc;
    fat_base = f_rsvd + part_start;
    data_base = fat_span + span + fat_base;
    root_base = wide[0] ? (rc - 2) * f_spc + data_base : fat_base + fat_span;
    vol_bps = f_bps;
    vol_spc = f_spc;
    return 1;
  endfunction

  // note one accepted input transaction
  function void note_input(logic [1:0] op, logic [7:0] b, logic last, logic [27:0] cl);
    logic [31:0] p, fo, div, s;
    p = pos;
    if (phase == PH_FAIL) begin
      if (op == OPC_FIRST || op == OPC_LOOKUP) add(KIND_ERROR, 0, 0);
      return;
    end
    if (op == OPC_BYTE && (phase == PH_BOOT0 || phase == PH_BOOT1)) begin
      if (p == 0) begin
        clear_fields();
        if (phase == PH_BOOT0) part_start = 0;
        hdr_ok = (b == JMP_SHORT || b == JMP_NEAR) ? 32'd1 : 32'd0;
      end
      if (p < BOOT_SECTOR_BYTES) begin
        f_bps = take(f_bps, p, 'h0B, 2, b);
        f_spc = take(f_spc, p, 'h0D, 1, b);
        f_rsvd = take(f_rsvd, p, 'h0E, 2, b);
        f_nfats = take(f_nfats, p, 'h10, 1, b);
        f_rootent = take(f_rootent, p, 'h11, 2, b);
        f_tot16 = take(f_tot16, p, 'h13, 2, b);
        f_fat16 = take(f_fat16, p, 'h16, 2, b);
        f_tot32 = take(f_tot32, p, 'h20, 4, b);
        f_fat32 = take(f_fat32, p, 'h24, 4, b);
        f_rootclus = take(f_rootclus, p, 'h2C, 4, b);
        if (phase == PH_BOOT0) part_start = take(part_start, p, 'h1C6, 4, b);
      end
      if (p < MAX_SECTOR_BYTES) pos = p + 1;
      if (!last) return;
      pos = 0;
      if (hdr_ok != 0) begin
        if (phase == PH_BOOT0) part_start = 0;
        if (mount()) begin
          phase = PH_READY;
          add(KIND_MOUNTED, 0, 0);
        end else begin
          phase = PH_FAIL;
          add(KIND_ERROR, 0, 0);
        end
      end else if (phase == PH_BOOT0) begin
        phase = PH_BOOT1;
        add(KIND_READ, part_start, 0);
      end else begin
        phase = PH_FAIL;
        add(KIND_ERROR, 0, 0);
      end
      return;
    end
    if (op == OPC_BYTE && phase == PH_FAT) begin
      if (p == 0) entry_val = 0;
      if (p < MAX_SECTOR_BYTES) begin
        entry_val = take(entry_val, p, entry_ofs, wide[0] ? 4 : 2, b);
        pos = p + 1;
      end
      if (!last) return;
      pos = 0;
      phase = PH_READY;
      add(KIND_NEXT, 0, wide[0] ? (entry_val & FAT32_ENTRY_MASK) : (entry_val & 32'hFFFF));
      return;
    end
    if (phase != PH_READY) return;
    if (op == OPC_FIRST) begin
      s = (cl == 0) ? root_base : ({4'd0, cl} - 2) * vol_spc + data_base;
      add(KIND_FIRST, s, 0);
    end else if (op == OPC_LOOKUP) begin
      fo = {4'd0, cl} * (wide[0] ? 32'd4 : 32'd2);
      div = (vol_bps != 0) ? vol_bps : 32'd1;
      entry_ofs = fo % div;
      entry_val = 0;
      pos = 0;
      phase = PH_FAT;
      add(KIND_READ, fo / div + fat_base, 0);
    end
  endfunction

  // compare one accepted result transaction with the oldest expectation
  function void check_result(vol_result_t a);
    vol_result_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result kind %0d", $time, a.kind);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    if (a.kind != e.kind) report("kind", e.kind, a.kind);
    if (a.sector != e.sector) report("sector", e.sector, a.sector);
    if (a.next_cl != e.next_cl) report("next_cluster", e.next_cl, a.next_cl);
    if (a.wide != e.wide) report("is_fat32", e.wide, a.wide);
    if (a.bps != e.bps) report("bytes_per_sector", e.bps, a.bps);
    if (a.spc != e.spc) report("sectors_per_cluster", e.spc, a.spc);
    if (a.fat_start != e.fat_start) report("fat_start_sector", e.fat_start, a.fat_start);
    if (a.data_start != e.data_start)
      report("first_data_sector", e.data_start, a.data_start);
    if (a.root_start != e.root_start) report("root_dir_sector", e.root_start, a.root_start);
    if (a.root_secs != e.root_secs) report("root_dir_sectors", e.root_secs, a.root_secs);
    if (a.clus_cnt != e.clus_cnt) report("data_clusters", e.clus_cnt, a.clus_cnt);
  endfunction

  function void report(string f, logic [31:0] e, logic [31:0] a);
    $display("%0t: %s expected %h actual %h", $time, f, e, a);
    errors++;
  endfunction
endclass

module tb;
  import fvm_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = OPC_BYTE;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic [27:0] cluster_i = 28'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] sector_o;
  logic [27:0] next_cluster_o;
  logic        is_fat32_o;
  logic [15:0] bytes_per_sector_o;
  logic [7:0]  sectors_per_cluster_o;
  logic [31:0] fat_start_sector_o;
  logic [31:0] first_data_sector_o;
  logic [31:0] root_dir_sector_o;
  logic [15:0] root_dir_sectors_o;
  logic [31:0] data_clusters_o;

  fat_volume_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned pop_wait = 0;
  bit          burst = 1'b0;
  logic [7:0]  boot_img[0:511];

  fat_volume_mount_and_cluster_map dut (.*);

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random pop stalls, check each accepted transaction
  always @(posedge clk_i) begin
    vol_result_t a;
    if (rst_ni) begin
      if (pop && !empty) begin
        a.kind = kind_e'(kind_o); a.sector = sector_o; a.next_cl = next_cluster_o;
        a.wide = is_fat32_o; a.bps = bytes_per_sector_o; a.spc = sectors_per_cluster_o;
        a.fat_start = fat_start_sector_o; a.data_start = first_data_sector_o;
        a.root_start = root_dir_sector_o; a.root_secs = root_dir_sectors_o;
        a.clus_cnt = data_clusters_o;
        sb.check_result(a);
        pop_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // send one transaction and wait for acceptance, then an optional gap
  task automatic send(logic [1:0] op, logic [7:0] b, logic last, logic [27:0] cl,
                      bit counted = 1);
    int unsigned gap;
    push <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    last_byte_i <= last;
    cluster_i <= cl;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(op, b, last, cl);
    if (counted) sent++;
    if ($urandom_range(0, 63) == 0) burst = ~burst;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_sector(int len, logic [7:0] first_b);
    for (int i = 0; i < len; i++)
      send(OPC_BYTE, (i == 0) ? first_b : 8'($urandom), i == len - 1, 28'($urandom));
  endtask

  task automatic send_image(int len);
    for (int i = 0; i < len; i++)
      send(OPC_BYTE, (i < 512) ? boot_img[i] : 8'($urandom), i == len - 1, 28'd0);
  endtask

  task automatic put16(int off, logic [15:0] v);
    boot_img[off] = v[7:0];
    boot_img[off + 1] = v[15:8];
  endtask

  task automatic put32(int off, logic [31:0] v);
    put16(off, v[15:0]);
    put16(off + 2, v[31:16]);
  endtask

  // build a boot sector image: style 0 FAT16, 1 FAT32, 2 arbitrary fields
  task automatic build_boot(int style, logic [15:0] bps, logic [7:0] spc);
    for (int i = 0; i < 512; i++) boot_img[i] = 8'($urandom);
    boot_img[0] = $urandom_range(0, 1) ? JMP_SHORT : JMP_NEAR;
    put16('h0B, bps);
    boot_img['h0D] = spc;
    if (style == 0) begin
      put16('h0E, 16'($urandom_range(1, 64)));
      boot_img['h10] = 8'($urandom_range(1, 2));
      put16('h11, 16'($urandom_range(0, 1024)));
      put16('h13, 16'($urandom_range(20000, 65535)));
      put16('h16, 16'($urandom_range(1, 256)));
    end else if (style == 1) begin
      put16('h0E, 16'($urandom_range(1, 64)));
      boot_img['h10] = 8'($urandom_range(1, 2));
      put16('h11, 16'd0);
      put16('h13, 16'd0);
      put16('h16, 16'd0);
      put32('h20, 32'h0100_0000 + 32'($urandom_range(0, 32'h00FF_FFFF)));
      put32('h24, 32'($urandom_range(1, 65536)));
    end
  endtask

  function automatic logic [15:0] pick_bps();
    case ($urandom_range(0, 5))
      0: return 16'd512;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(2, 64));
    endcase
  endfunction

  // stream the FAT sector after a lookup, mostly long enough to hold the entry
  task automatic send_fat_sector();
    int len;
    int need;
    need = sb.entry_ofs + (sb.wide[0] ? 4 : 2);
    if (need > 600) len = $urandom_range(1, 40);
    else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, need);
    else len = need + $urandom_range(0, 6);
    send_sector(len, 8'($urandom));
  endtask

  initial begin
    int mode;
    int style;
    logic [15:0] bps;
    logic [7:0] spc;
    logic [27:0] cl;
    int r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // queries before mount and the unused opcode are dropped
    send(OPC_FIRST, 8'h00, 1'b0, 28'hFFF_FFFF);
    send(OPC_LOOKUP, 8'hFF, 1'b1, 28'd0);
    send(OP_NONE, 8'hFF, 1'b1, 28'hFFF_FFFF);

    mode = $urandom_range(0, 7);
    style = $urandom_range(0, 2);
    bps = pick_bps();
    spc = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 8));
    build_boot(style, bps, spc);
    if (mode == 0) begin
      // failing mounts: second sector not a boot sector, or a zero divisor
      r = $urandom_range(0, 2);
      if (r == 0) begin
        send_sector(512, 8'h00);
        send_sector($urandom_range(1, 40), 8'h55);
      end else begin
        if (r == 1) put16('h0B, 16'd0);
        else boot_img['h0D] = 8'd0;
        send_image(512);
      end
    end else begin
      // optional partition table in sector 0, sometimes short
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < 512; i++) begin
          r = $urandom;
          if (i == 0) r = 8'h00;
          send(OPC_BYTE, 8'(r), i == 511, 28'($urandom));
        end
      end else if ($urandom_range(0, 3) == 0) begin
        send_sector($urandom_range(1, 100), 8'hFF);
      end
      case ($urandom_range(0, 3))
        0: send_image(48);
        1: send_image(600);
        default: send_image(512);
      endcase
    end

    // hold off until every result of the mount is back
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);

    // directed queries on the extremes of the cluster field
    send(OPC_FIRST, 8'h00, 1'b0, 28'd0);
    send(OPC_FIRST, 8'h00, 1'b0, 28'd1);
    send(OPC_FIRST, 8'h00, 1'b0, 28'd2);
    send(OPC_FIRST, 8'hFF, 1'b1, 28'hFFF_FFFF);
    send(OPC_BYTE, 8'hA5, 1'b1, 28'd0);
    if (sb.phase == PH_READY) begin
      send(OPC_LOOKUP, 8'h00, 1'b0, 28'hFFF_FFFF);
      send(OPC_FIRST, 8'h00, 1'b0, 28'd5);
      send_fat_sector();
      // long FAT sector past the byte position limit
      send(OPC_LOOKUP, 8'h00, 1'b0, 28'd3);
      send_sector(MAX_SECTOR_BYTES + 4, 8'hFF);
    end else begin
      send(OPC_LOOKUP, 8'h00, 1'b0, 28'hFFF_FFFF);
    end

    // random queries and lookups
    sent = 0;
    while (sent < 750) begin
      cl = ($urandom_range(0, 7) == 0) ? 28'($urandom_range(0, 3)) : 28'($urandom);
      r = $urandom_range(0, 9);
      if (r < 4) begin
        send(OPC_LOOKUP, 8'($urandom), 1'($urandom), cl);
        if (sb.phase == PH_FAT) begin
          if ($urandom_range(0, 4) == 0) send(OPC_FIRST, 8'd0, 1'b0, cl, 0);
          send_fat_sector();
        end
      end else if (r < 8) begin
        send(OPC_FIRST, 8'($urandom), 1'($urandom), cl);
      end else if (r == 8) begin
        send(OP_NONE, 8'($urandom), 1'($urandom), cl, 0);
      end else begin
        send(OPC_BYTE, 8'($urandom), 1'($urandom), cl, 0);
      end
    end
    push <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
